/* rtl/scct_pkg.sv */
// ----------------------------------------------------------------------------
// scct_pkg
// Shared constants for the segment / circle crossing test pipeline.
// ----------------------------------------------------------------------------
package scct_pkg;

    // default coordinate width, millimetres, two's complement
    localparam int DEF_COORD_WIDTH = 15;

    // number of register stages from input to result register
    localparam int NSTAGE = 7;

    // configuration port
    localparam int PADDR_WIDTH = 4;
    localparam int PDATA_WIDTH = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

endpackage

/* rtl/scct_ctrl.sv */
// ----------------------------------------------------------------------------
// scct_ctrl
// Valid bits and per-stage enables for the datapath; bubbles collapse,
// a stage holds only when everything downstream of it is full and stalled.
// ----------------------------------------------------------------------------
module scct_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [scct_pkg::NSTAGE-1:0] stage_en
);
    import scct_pkg::*;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] upstream;

    assign upstream = {valid_reg[NSTAGE-2:0], s_valid};

    always_comb begin
        stage_en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb begin
        for (int i = 0; i < NSTAGE; i++) begin
            valid_next[i] = stage_en[i] ? upstream[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NSTAGE-1];

endmodule

/* rtl/scct_front.sv */
// ----------------------------------------------------------------------------
// scct_front
// Stages 1-3: offsets from the center, all narrow products, then the sums
// (squared distances, squared length, cross product and dot products).
// ----------------------------------------------------------------------------
module scct_front #(
    parameter int COORD_WIDTH = scct_pkg::DEF_COORD_WIDTH
) (
    input  logic                              aclk,
    input  logic [2:0]                        en,
    input  logic signed [COORD_WIDTH-1:0]     start_x,
    input  logic signed [COORD_WIDTH-1:0]     start_y,
    input  logic signed [COORD_WIDTH-1:0]     end_x,
    input  logic signed [COORD_WIDTH-1:0]     end_y,
    input  logic signed [COORD_WIDTH-1:0]     center_x,
    input  logic signed [COORD_WIDTH-1:0]     center_y,
    input  logic [COORD_WIDTH-2:0]            circle_radius,
    output logic [2*COORD_WIDTH+1:0]          d2a,
    output logic [2*COORD_WIDTH+1:0]          d2b,
    output logic [2*COORD_WIDTH+1:0]          len2,
    output logic signed [2*COORD_WIDTH+2:0]   dot1n,
    output logic signed [2*COORD_WIDTH+2:0]   dot2,
    output logic signed [2*COORD_WIDTH+2:0]   crsn,
    output logic [2*COORD_WIDTH-3:0]          r2
);
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int RW2 = 2 * COORD_WIDTH - 2;

    // stage 1: offsets (d = point - center, ab = end - start)
    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg, abx_reg, aby_reg;

    // stage 2: products
    logic [PW-1:0]        sqax_reg, sqay_reg, sqbx_reg, sqby_reg, sqlx_reg, sqly_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, qa_reg, qb_reg;
    logic [RW2-1:0]       r2s2_reg;

    // stage 3: sums
    logic [PW-1:0]        d2a_reg, d2b_reg, len2_reg;
    logic signed [PW:0]   dot1n_reg, dot2_reg, crsn_reg;
    logic [RW2-1:0]       r2s3_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dax_reg <= DW'(start_x) - DW'(center_x);
            day_reg <= DW'(start_y) - DW'(center_y);
            dbx_reg <= DW'(end_x) - DW'(center_x);
            dby_reg <= DW'(end_y) - DW'(center_y);
            abx_reg <= DW'(end_x) - DW'(start_x);
            aby_reg <= DW'(end_y) - DW'(start_y);
        end
    end

    // ac = -da and bc = -db, so dot1 = -(ab.da), dot2 = ab.db, cross = -(ab x da)
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sqax_reg <= PW'(dax_reg * dax_reg);
            sqay_reg <= PW'(day_reg * day_reg);
            sqbx_reg <= PW'(dbx_reg * dbx_reg);
            sqby_reg <= PW'(dby_reg * dby_reg);
            sqlx_reg <= PW'(abx_reg * abx_reg);
            sqly_reg <= PW'(aby_reg * aby_reg);
            pa_reg   <= PW'(abx_reg * dax_reg);
            pb_reg   <= PW'(aby_reg * day_reg);
            pc_reg   <= PW'(abx_reg * day_reg);
            pd_reg   <= PW'(aby_reg * dax_reg);
            qa_reg   <= PW'(abx_reg * dbx_reg);
            qb_reg   <= PW'(aby_reg * dby_reg);
            r2s2_reg <= RW2'(circle_radius) * RW2'(circle_radius);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            d2a_reg   <= sqax_reg + sqay_reg;
            d2b_reg   <= sqbx_reg + sqby_reg;
            len2_reg  <= sqlx_reg + sqly_reg;
            dot1n_reg <= (PW+1)'(pa_reg) + (PW+1)'(pb_reg);
            dot2_reg  <= (PW+1)'(qa_reg) + (PW+1)'(qb_reg);
            crsn_reg  <= (PW+1)'(pc_reg) - (PW+1)'(pd_reg);
            r2s3_reg  <= r2s2_reg;
        end
    end

    assign d2a   = d2a_reg;
    assign d2b   = d2b_reg;
    assign len2  = len2_reg;
    assign dot1n = dot1n_reg;
    assign dot2  = dot2_reg;
    assign crsn  = crsn_reg;
    assign r2    = r2s3_reg;

endmodule

/* rtl/scct_eval.sv */
// ----------------------------------------------------------------------------
// scct_eval
// Stage 4: endpoint compares, sign tests on the dot products, cross product
// magnitude for the wide compare.
// ----------------------------------------------------------------------------
module scct_eval #(
    parameter int COORD_WIDTH = scct_pkg::DEF_COORD_WIDTH
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [2*COORD_WIDTH+1:0]          d2a,
    input  logic [2*COORD_WIDTH+1:0]          d2b,
    input  logic [2*COORD_WIDTH+1:0]          len2,
    input  logic signed [2*COORD_WIDTH+2:0]   dot1n,
    input  logic signed [2*COORD_WIDTH+2:0]   dot2,
    input  logic signed [2*COORD_WIDTH+2:0]   crsn,
    input  logic [2*COORD_WIDTH-3:0]          r2,
    output logic                              start_in,
    output logic                              end_in,
    output logic                              seg_ok,
    output logic [2*COORD_WIDTH+1:0]          cmag,
    output logic [2*COORD_WIDTH+1:0]          len2_out,
    output logic [2*COORD_WIDTH-3:0]          r2_out
);
    localparam int PW = 2 * COORD_WIDTH + 2;

    logic          start_in_reg, end_in_reg, seg_ok_reg;
    logic [PW-1:0] cmag_reg, len2_reg;
    logic [2*COORD_WIDTH-3:0] r2_reg;
    logic signed [PW:0] crs_abs;

    assign crs_abs = crsn[PW] ? -crsn : crsn;

    always_ff @(posedge aclk) begin
        if (en) begin
            start_in_reg <= d2a <= PW'(r2);
            end_in_reg   <= d2b <= PW'(r2);
            // nonzero length, dot1 >= 0 (dot1n <= 0) and dot2 >= 0
            seg_ok_reg   <= (len2 != '0) && (dot1n[PW] || dot1n == '0) && !dot2[PW];
            cmag_reg     <= crs_abs[PW-1:0];
            len2_reg     <= len2;
            r2_reg       <= r2;
        end
    end

    assign start_in = start_in_reg;
    assign end_in   = end_in_reg;
    assign seg_ok   = seg_ok_reg;
    assign cmag     = cmag_reg;
    assign len2_out = len2_reg;
    assign r2_out   = r2_reg;

endmodule

/* rtl/scct_wide_cmp.sv */
// ----------------------------------------------------------------------------
// scct_wide_cmp
// Stages 5-7: cross^2 <= r^2 * len^2 on split operands. Half-width partial
// products, then recombination, then the compare and the result register.
// ----------------------------------------------------------------------------
module scct_wide_cmp #(
    parameter int COORD_WIDTH = scct_pkg::DEF_COORD_WIDTH
) (
    input  logic                              aclk,
    input  logic [2:0]                        en,
    input  logic                              start_in,
    input  logic                              end_in,
    input  logic                              seg_ok,
    input  logic [2*COORD_WIDTH+1:0]          cmag,
    input  logic [2*COORD_WIDTH+1:0]          len2,
    input  logic [2*COORD_WIDTH-3:0]          r2,
    output logic                              crosses,
    output logic                              start_inside,
    output logic                              end_inside
);
    localparam int H  = COORD_WIDTH + 1;
    localparam int FW = 4 * H;

    logic [2*H-1:0] r2x;
    logic [H-1:0]   ch, cl, lh, ll, rh, rl;

    // stage 5
    logic [2*H-1:0] chh_reg, chl_reg, cll_reg;
    logic [2*H-1:0] rhh_reg, rhl_reg, rlh_reg, rll_reg;
    logic [2:0]     flag5_reg;
    // stage 6
    logic [FW-1:0]  lhs_reg, rhs_reg;
    logic [2:0]     flag6_reg;
    // stage 7
    logic           crosses_reg, start_inside_reg, end_inside_reg;

    assign r2x = (2*H)'(r2);
    assign ch  = cmag[2*H-1:H];
    assign cl  = cmag[H-1:0];
    assign lh  = len2[2*H-1:H];
    assign ll  = len2[H-1:0];
    assign rh  = r2x[2*H-1:H];
    assign rl  = r2x[H-1:0];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            chh_reg   <= (2*H)'(ch * ch);
            chl_reg   <= (2*H)'(ch * cl);
            cll_reg   <= (2*H)'(cl * cl);
            rhh_reg   <= (2*H)'(rh * lh);
            rhl_reg   <= (2*H)'(rh * ll);
            rlh_reg   <= (2*H)'(rl * lh);
            rll_reg   <= (2*H)'(rl * ll);
            flag5_reg <= {seg_ok, end_in, start_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            // cross term appears twice in the square: shift by H+1
            lhs_reg   <= (FW'(chh_reg) << (2*H)) + (FW'(chl_reg) << (H+1)) + FW'(cll_reg);
            rhs_reg   <= (FW'(rhh_reg) << (2*H))
                       + ((FW'(rhl_reg) + FW'(rlh_reg)) << H) + FW'(rll_reg);
            flag6_reg <= flag5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            crosses_reg      <= flag6_reg[0] || flag6_reg[1]
                              || (flag6_reg[2] && (lhs_reg <= rhs_reg));
            start_inside_reg <= flag6_reg[0];
            end_inside_reg   <= flag6_reg[1];
        end
    end

    assign crosses      = crosses_reg;
    assign start_inside = start_inside_reg;
    assign end_inside   = end_inside_reg;

endmodule

/* rtl/segment_circle_crossing_test.sv */
// ----------------------------------------------------------------------------
// segment_circle_crossing_test
// Segment versus configured circle crossing test, pipelined.
// ----------------------------------------------------------------------------
// Each request is one segment; one result comes back per request, and a new
// segment can be taken every cycle unless a full pipeline is stalled. The
// seven register stages are set by the arithmetic: offsets, products, sums,
// compares, split partial products of the wide cross^2 versus r^2 * len^2
// test, their recombination, and the final compare into the result register.
// A stalled result only holds back stages that are full; empty stages keep
// taking requests. The user writes center and radius through the APB port
// only while no request is in flight; the block does not enforce this. Reads
// return them sign- or zero-extended.
module segment_circle_crossing_test #(
    parameter int COORD_WIDTH = scct_pkg::DEF_COORD_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [scct_pkg::PADDR_WIDTH-1:0]     paddr,
    input  logic [scct_pkg::PDATA_WIDTH-1:0]     pwdata,
    output logic [scct_pkg::PDATA_WIDTH-1:0]     prdata,
    output logic                                 pready,
    // segment requests
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_start_x,
    input  logic signed [COORD_WIDTH-1:0]        s_start_y,
    input  logic signed [COORD_WIDTH-1:0]        s_end_x,
    input  logic signed [COORD_WIDTH-1:0]        s_end_y,
    // results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_crosses,
    output logic                                 m_start_inside,
    output logic                                 m_end_inside
);
    import scct_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W + 2;

    logic signed [W-1:0] center_x_reg, center_y_reg;
    logic [W-2:0]        radius_reg;
    logic                cfg_wr;
    logic [NSTAGE-1:0]   stage_en;

    logic [PW-1:0]        d2a, d2b, len2, cmag, len2_e;
    logic signed [PW:0]   dot1n, dot2, crsn;
    logic [2*W-3:0]       r2, r2_e;
    logic                 start_in, end_in, seg_ok;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_CENTER_X: center_x_reg <= pwdata[W-1:0];
                REG_CENTER_Y: center_y_reg <= pwdata[W-1:0];
                REG_RADIUS:   radius_reg   <= pwdata[W-2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CENTER_X: prdata = PDATA_WIDTH'(center_x_reg);
            REG_CENTER_Y: prdata = PDATA_WIDTH'(center_y_reg);
            REG_RADIUS:   prdata = PDATA_WIDTH'(radius_reg);
            default:      prdata = '0;
        endcase
    end

    scct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stage_en (stage_en)
    );

    scct_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk          (aclk),
        .en            (stage_en[2:0]),
        .start_x       (s_start_x),
        .start_y       (s_start_y),
        .end_x         (s_end_x),
        .end_y         (s_end_y),
        .center_x      (center_x_reg),
        .center_y      (center_y_reg),
        .circle_radius (radius_reg),
        .d2a           (d2a),
        .d2b           (d2b),
        .len2          (len2),
        .dot1n         (dot1n),
        .dot2          (dot2),
        .crsn          (crsn),
        .r2            (r2)
    );

    scct_eval #(.COORD_WIDTH(COORD_WIDTH)) u_eval (
        .aclk     (aclk),
        .en       (stage_en[3]),
        .d2a      (d2a),
        .d2b      (d2b),
        .len2     (len2),
        .dot1n    (dot1n),
        .dot2     (dot2),
        .crsn     (crsn),
        .r2       (r2),
        .start_in (start_in),
        .end_in   (end_in),
        .seg_ok   (seg_ok),
        .cmag     (cmag),
        .len2_out (len2_e),
        .r2_out   (r2_e)
    );

    scct_wide_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_wide_cmp (
        .aclk         (aclk),
        .en           (stage_en[6:4]),
        .start_in     (start_in),
        .end_in       (end_in),
        .seg_ok       (seg_ok),
        .cmag         (cmag),
        .len2         (len2_e),
        .r2           (r2_e),
        .crosses      (m_crosses),
        .start_inside (m_start_inside),
        .end_inside   (m_end_inside)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the segment / circle crossing test pipeline: directed corner
// segments, then random segments under several circle settings. Results are
// checked in order against a local predictor, with random source gaps and
// result back-pressure throughout.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW          = scct_pkg::DEF_COORD_WIDTH;
    localparam int CMAX        = 2 ** (CW - 1) - 1;
    localparam int CMIN        = -(2 ** (CW - 1));
    localparam int RMAX        = 2 ** (CW - 1) - 1;
    localparam int CYCLE_LIMIT = 900000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 150;

    // no register behind this index; writes must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } segment_t;

    typedef struct packed {
        logic crosses;
        logic start_in;
        logic end_in;
    } verdict_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                             psel    = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite  = 1'b0;
    logic [scct_pkg::PADDR_WIDTH-1:0] paddr   = '0;
    logic [scct_pkg::PDATA_WIDTH-1:0] pwdata  = '0;
    logic [scct_pkg::PDATA_WIDTH-1:0] prdata;
    logic                             pready;

    logic   s_valid   = 1'b0;
    logic   s_ready;
    coord_t s_start_x = '0;
    coord_t s_start_y = '0;
    coord_t s_end_x   = '0;
    coord_t s_end_y   = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    logic m_crosses;
    logic m_start_inside;
    logic m_end_inside;

    // circle as the block should currently hold it
    coord_t        ctr_x = '0;
    coord_t        ctr_y = '0;
    logic [CW-2:0] rad   = '0;

    segment_t segment_q[$];
    verdict_t verdict_q[$];

    int       err_count = 0;
    int       cycle_cnt = 0;
    logic     s_took    = 1'b0;
    int       src_pause = 0;
    bit       src_quiet = 1'b0;
    int       snk_stall = 0;
    bit       snk_quiet = 1'b0;
    verdict_t want;

    always #2 aclk = ~aclk;

    segment_circle_crossing_test u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crosses      (m_crosses),
        .m_start_inside (m_start_inside),
        .m_end_inside   (m_end_inside)
    );

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] exp_val);
        $display("[%0d] mismatch %s: got %0h, expected %0h", cycle_cnt, what, got, exp_val);
        err_count++;
    endtask

    // exact wide arithmetic: cross^2 reaches about 2^62, so 128 bits is plenty
    function automatic verdict_t predict_crossing(segment_t sg);
        logic signed [127:0] ax, ay, bx, by, cx, cy, rr, r2;
        logic signed [127:0] abx, aby, acx, acy, bcx, bcy, len2, crs, dot1, dot2;
        verdict_t v;
        ax = $signed(sg.ax);
        ay = $signed(sg.ay);
        bx = $signed(sg.bx);
        by = $signed(sg.by);
        cx = ctr_x;
        cy = ctr_y;
        rr = rad;
        r2 = rr * rr;
        acx = cx - ax;
        acy = cy - ay;
        bcx = cx - bx;
        bcy = cy - by;
        v.start_in = (acx * acx + acy * acy) <= r2;
        v.end_in   = (bcx * bcx + bcy * bcy) <= r2;
        abx  = bx - ax;
        aby  = by - ay;
        len2 = abx * abx + aby * aby;
        crs  = abx * acy - aby * acx;
        dot1 = abx * acx + aby * acy;
        dot2 = -(abx * bcx) - aby * bcy;
        v.crosses = v.start_in || v.end_in ||
                    (len2 != 0 && crs * crs <= r2 * len2 && dot1 >= 0 && dot2 >= 0);
        return v;
    endfunction

    function automatic coord_t clip(int v);
        if (v < CMIN) return coord_t'(CMIN);
        if (v > CMAX) return coord_t'(CMAX);
        return coord_t'(v);
    endfunction

    function automatic int near_offset(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic coord_t pick_extreme(int around);
        case ($urandom_range(0, 5))
            0: return coord_t'(CMIN);
            1: return coord_t'(CMAX);
            2: return '0;
            3: return '1;
            4: return clip(around);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic segment_t random_segment();
        segment_t sg;
        int cx, cy, r, span, d, p, q, tmp;
        cx   = ctr_x;
        cy   = ctr_y;
        r    = rad;
        span = 2 * r + 8;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                sg = segment_t'({$urandom, $urandom});
            end
            3, 4, 5, 6: begin
                sg.ax = clip(cx + near_offset(span));
                sg.ay = clip(cy + near_offset(span));
                sg.bx = clip(cx + near_offset(span));
                sg.by = clip(cy + near_offset(span));
            end
            7: begin
                // axis-parallel chord at or just beside the tangent distance
                case ($urandom_range(0, 3))
                    0: d = r - 1;
                    1: d = r;
                    2: d = r + 1;
                    default: d = -r;
                endcase
                p = cx + near_offset(span + 12);
                q = cx + near_offset(span + 12);
                sg.ax = clip(p);
                sg.bx = clip(q);
                sg.ay = clip(cy + d);
                sg.by = clip(cy + d);
                if ($urandom_range(0, 1) == 1) begin
                    sg.ax = clip(cx + d);
                    sg.bx = clip(cx + d);
                    sg.ay = clip(cy + p - cx);
                    sg.by = clip(cy + q - cx);
                end
            end
            8: begin
                // zero length, often right on the boundary
                case ($urandom_range(0, 4))
                    0: begin p = cx + r; q = cy; end
                    1: begin p = cx - r; q = cy; end
                    2: begin p = cx; q = cy + r + $urandom_range(0, 1); end
                    3: begin p = cx; q = cy; end
                    default: begin p = cx + near_offset(span); q = cy + near_offset(span); end
                endcase
                sg.ax = clip(p);
                sg.ay = clip(q);
                sg.bx = sg.ax;
                sg.by = sg.ay;
            end
            default: begin
                sg.ax = pick_extreme(cx);
                sg.ay = pick_extreme(cy);
                sg.bx = pick_extreme(cx);
                sg.by = pick_extreme(cy);
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            tmp   = sg.ax;
            sg.ax = sg.bx;
            sg.bx = coord_t'(tmp);
            tmp   = sg.ay;
            sg.ay = sg.by;
            sg.by = coord_t'(tmp);
        end
        return sg;
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int draw_pause();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!(psel && penable && pready));
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        logic [31:0] rd, exp_rd;
        apb_access(1'b1, idx, data, rd);
        case (idx)
            scct_pkg::REG_CENTER_X: ctr_x = data[CW-1:0];
            scct_pkg::REG_CENTER_Y: ctr_y = data[CW-1:0];
            scct_pkg::REG_RADIUS:   rad   = data[CW-2:0];
            default: ;
        endcase
        if (idx != REG_UNUSED) begin
            apb_access(1'b0, idx, '0, rd);
            case (idx)
                scct_pkg::REG_CENTER_X: exp_rd = 32'(ctr_x);
                scct_pkg::REG_CENTER_Y: exp_rd = 32'(ctr_y);
                default:                exp_rd = 32'(rad);
            endcase
            if (rd !== exp_rd) flag_error("register readback", rd, exp_rd);
        end
    endtask

    // junk above the field width must be dropped by the block
    task automatic set_circle(input int cx, input int cy, input int r);
        write_reg(scct_pkg::REG_CENTER_X, ($urandom & ~32'h7fff) | (cx & 32'h7fff));
        write_reg(scct_pkg::REG_CENTER_Y, ($urandom & ~32'h7fff) | (cy & 32'h7fff));
        write_reg(scct_pkg::REG_RADIUS,   ($urandom & ~32'h3fff) | (r & 32'h3fff));
        if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
    endtask

    task automatic queue_seg(input int ax, input int ay, input int bx, input int by);
        segment_t sg;
        sg.ax = coord_t'(ax);
        sg.ay = coord_t'(ay);
        sg.bx = coord_t'(bx);
        sg.by = coord_t'(by);
        segment_q.push_back(sg);
    endtask

    task automatic drain();
        while (segment_q.size() != 0 || s_valid || verdict_q.size() != 0) @(posedge aclk);
        repeat (scct_pkg::NSTAGE + 2) @(posedge aclk);
    endtask

    // request source
    always @(negedge aclk) begin
        segment_t sg;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (src_pause > 0) begin
                src_pause--;
                s_valid <= 1'b0;
            end else if (segment_q.size() != 0) begin
                sg = segment_q.pop_front();
                s_start_x <= sg.ax;
                s_start_y <= sg.ay;
                s_end_x   <= sg.bx;
                s_end_y   <= sg.by;
                s_valid   <= 1'b1;
                if ($urandom_range(0, 49) == 0) src_quiet = !src_quiet;
                src_pause = src_quiet ? 0 : draw_pause();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (snk_stall > 0) begin
            snk_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!snk_quiet && $urandom_range(0, 5) == 0) snk_stall = draw_pause();
            if ($urandom_range(0, 59) == 0) snk_quiet = !snk_quiet;
        end
    end

    // result check first, then log the request taken at this edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    flag_error("result with no request pending", 32'(m_crosses), '0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_crosses !== want.crosses)
                        flag_error("crosses", 32'(m_crosses), 32'(want.crosses));
                    if (m_start_inside !== want.start_in)
                        flag_error("start_inside", 32'(m_start_inside), 32'(want.start_in));
                    if (m_end_inside !== want.end_in)
                        flag_error("end_inside", 32'(m_end_inside), 32'(want.end_in));
                end
            end
            if (s_valid && s_ready)
                verdict_q.push_back(predict_crossing({s_start_x, s_start_y, s_end_x, s_end_y}));
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int cx, cy, r;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // tangency, boundary points, zero length, foot off the segment, extremes
        set_circle(0, 0, 100);
        queue_seg(-200, 100, 200, 100);
        queue_seg(-200, 101, 200, 101);
        queue_seg(100, 0, 500, 0);
        queue_seg(500, 0, 0, -100);
        queue_seg(100, 0, 100, 0);
        queue_seg(101, 0, 101, 0);
        queue_seg(200, 0, 300, 0);
        queue_seg(-300, -300, 300, 300);
        queue_seg(CMIN, CMIN, CMAX, CMAX);
        queue_seg(CMAX, CMIN, CMIN, CMAX);
        queue_seg(CMIN, CMAX, CMIN, CMIN);
        queue_seg(CMAX, CMAX, CMAX, CMAX);
        queue_seg(-1, -1, 0, 0);
        queue_seg(-100, -500, -100, 500);
        drain();

        // zero radius: only exact hits on the center count
        set_circle(5, -7, 0);
        queue_seg(5, -7, 5, -7);
        queue_seg(2, -10, 8, -4);
        queue_seg(2, -10, 8, -3);
        queue_seg(5, -7, 100, 100);
        queue_seg(6, -7, 6, -7);
        queue_seg(CMIN, -7, CMAX, -7);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin cx = 0;    cy = 0;    r = RMAX; end
                1: begin cx = CMIN; cy = CMIN; r = RMAX; end
                2: begin cx = CMAX; cy = CMAX; r = 0;    end
                3: begin cx = CMAX; cy = CMIN; r = 1;    end
                4: begin cx = CMIN; cy = CMAX; r = 8191; end
                default: begin
                    cx = int'(coord_t'($urandom));
                    cy = int'(coord_t'($urandom));
                    r  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, RMAX)
                                                     : $urandom_range(0, 2000);
                end
            endcase
            set_circle(cx, cy, r);
            repeat (PHASE_ITEMS) segment_q.push_back(random_segment());
            drain();
        end

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/scct_pkg.sv
rtl/scct_ctrl.sv
rtl/scct_front.sv
rtl/scct_eval.sv
rtl/scct_wide_cmp.sv
rtl/segment_circle_crossing_test.sv
bench/tb.sv
